FILE: design/pit_pkg.sv
`timescale 1ns / 1ps

package pit_pkg;

    // Item kind, carried on s_tuser
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } func_t;

    // Per-channel register select
    typedef enum logic [1:0] {
        REG_LOAD  = 2'd0,
        REG_COUNT = 2'd1,
        REG_CTRL  = 2'd2,
        REG_FLAG  = 2'd3
    } reg_sel_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ACCESS = 2'd1,
        ST_ZERO_LOAD = 2'd2
    } status_t;

    // Configuration register indexes
    localparam logic CFG_MODULE_ENABLE   = 1'b0;
    localparam logic CFG_FREEZE_IN_DEBUG = 1'b1;

    localparam int DATA_W    = 32;
    localparam int CHAN_IN_W = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // One request handed from the input register to the channel bank
    typedef struct packed {
        logic                 fire;
        logic [1:0]           func;
        logic [CHAN_IN_W-1:0] channel;
        logic [1:0]           reg_sel;
        logic [DATA_W-1:0]    write_data;
        logic                 debug_halt;
        logic                 module_enable;
        logic                 freeze_in_debug;
    } pit_cmd_t;

    // Result of one request
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [1:0]        status;
        logic              irq;
    } pit_res_t;

endpackage

FILE: design/pit_core.sv
`timescale 1ns / 1ps

module pit_core #(
    parameter int CHANNELS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pit_pkg::pit_cmd_t cmd,
    output pit_pkg::pit_res_t res
);
    import pit_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [CHANNELS-1:0][DATA_W-1:0] load_reg, load_next;
    logic [CHANNELS-1:0][DATA_W-1:0] count_reg, count_next;
    logic [CHANNELS-1:0]             en_reg, en_next;
    logic [CHANNELS-1:0]             irqen_reg, irqen_next;
    logic [CHANNELS-1:0]             flag_reg, flag_next;

    logic            tick_go;
    logic            ch_ok;
    logic [CH_W-1:0] idx;

    assign tick_go = cmd.module_enable && !(cmd.freeze_in_debug && cmd.debug_halt);
    assign ch_ok   = ({1'b0, cmd.channel} < (CHAN_IN_W + 1)'(CHANNELS));
    assign idx     = CH_W'(cmd.channel);

    always_comb begin
        load_next     = load_reg;
        count_next    = count_reg;
        en_next       = en_reg;
        irqen_next    = irqen_reg;
        flag_next     = flag_reg;
        res.read_data = '0;
        res.status    = ST_OK;

        case (func_t'(cmd.func))
            FUNC_TICK: begin
                if (tick_go) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (en_reg[c]) begin
                            if (count_reg[c] == '0) begin
                                count_next[c] = load_reg[c];
                                flag_next[c]  = 1'b1;
                            end else begin
                                count_next[c] = count_reg[c] - 1'b1;
                            end
                        end
                    end
                end
            end
            FUNC_READ: begin
                if (!ch_ok) begin
                    res.status = ST_BAD_ACCESS;
                end else begin
                    case (reg_sel_t'(cmd.reg_sel))
                        REG_LOAD:  res.read_data = load_reg[idx];
                        REG_COUNT: res.read_data = count_reg[idx];
                        REG_CTRL:  res.read_data = {{(DATA_W-2){1'b0}}, irqen_reg[idx], en_reg[idx]};
                        REG_FLAG:  res.read_data = {{(DATA_W-1){1'b0}}, flag_reg[idx]};
                        default:   res.read_data = '0;
                    endcase
                end
            end
            FUNC_WRITE: begin
                if (!ch_ok) begin
                    res.status = ST_BAD_ACCESS;
                end else begin
                    case (reg_sel_t'(cmd.reg_sel))
                        REG_LOAD: begin
                            if (cmd.write_data == '0) begin
                                res.status = ST_ZERO_LOAD;
                            end else begin
                                load_next[idx] = cmd.write_data;
                            end
                        end
                        REG_COUNT: begin
                            res.status = ST_BAD_ACCESS;
                        end
                        REG_CTRL: begin
                            // Rising enable restarts the count from the load value
                            if (cmd.write_data[0] && !en_reg[idx]) begin
                                count_next[idx] = load_reg[idx];
                            end
                            en_next[idx]    = cmd.write_data[0];
                            irqen_next[idx] = cmd.write_data[1];
                        end
                        REG_FLAG: begin
                            if (cmd.write_data[0]) begin
                                flag_next[idx] = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        res.irq = |(flag_next & irqen_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg  <= '0;
            count_reg <= '0;
            en_reg    <= '0;
            irqen_reg <= '0;
            flag_reg  <= '0;
        end else if (cmd.fire) begin
            load_reg  <= load_next;
            count_reg <= count_next;
            en_reg    <= en_next;
            irqen_reg <= irqen_next;
            flag_reg  <= flag_next;
        end
    end

    // A zero-load rejection only comes from a load write of zero
    a_zero_load_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fire && res.status == ST_ZERO_LOAD) |->
        (cmd.func == FUNC_WRITE && cmd.reg_sel == REG_LOAD && cmd.write_data == '0))
        else $error("zero-load status without a zero load write");

    // Flags only rise on a tick
    a_flag_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        ((flag_reg & ~$past(flag_reg)) != '0) |->
        $past(cmd.fire && cmd.func == FUNC_TICK))
        else $error("timeout flag set outside a tick");

    // A blocked tick leaves every count untouched
    a_blocked_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fire && cmd.func == FUNC_TICK && !tick_go) |=> $stable(count_reg))
        else $error("count moved on a blocked tick");

    // Load values change only on an accepted request
    a_load_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.fire |=> $stable(load_reg))
        else $error("load value changed without a request");

endmodule

FILE: design/periodic_interrupt_timer_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    tuser: func; tdata: channel, reg_sel, write_data,
//                                     debug_halt
// m_        out  m_tvalid/m_tready    tdata: read_data, status, irq
// cfg_      in   cfg_wr_en            cfg_addr: register index, cfg_wdata: value
//
// One request per cycle sustained while m_tready holds high; a result reaches m_tvalid through
// the input register, then the channel update into the result register.
// All channel state updates in the single cycle a request leaves the input register,
// so the next request always sees the previous one's effect.
// Reset is synchronous on aresetn low: all channel state and both config bits clear.
// A stall on m_tready holds the result register; s_tready stays high while the input
// register is empty or moves on in the same cycle.
module periodic_interrupt_timer_top #(
    parameter int CHANNELS = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Request stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [2:0] channel, [4:3] reg_sel, [36:5] write_data, [37] debug_halt, [39:38] zero
    input  logic [pit_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  logic [1:0]                   s_tuser,
    // Result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [31:0] read_data, [33:32] status, [34] irq, [39:35] zero
    output logic [pit_pkg::M_TDATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                         cfg_wr_en,
    input  logic                         cfg_addr,
    input  logic                         cfg_wdata
);
    import pit_pkg::*;

    logic                 in_valid_reg;
    logic [1:0]           func_reg;
    logic [CHAN_IN_W-1:0] channel_reg;
    logic [1:0]           reg_sel_reg;
    logic [DATA_W-1:0]    wdata_reg;
    logic                 halt_reg;

    logic module_enable_reg;
    logic freeze_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [1:0]        status_reg;
    logic              irq_reg;

    logic     advance;
    pit_cmd_t cmd;
    pit_res_t res;

    // Move the held request into the result register when that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Capture incoming requests
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg    <= s_tuser;
            channel_reg <= s_tdata[2:0];
            reg_sel_reg <= s_tdata[4:3];
            wdata_reg   <= s_tdata[36:5];
            halt_reg    <= s_tdata[37];
        end
    end

    // Configuration bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            module_enable_reg <= 1'b0;
            freeze_reg        <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MODULE_ENABLE:   module_enable_reg <= cfg_wdata;
                CFG_FREEZE_IN_DEBUG: freeze_reg        <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cmd.fire            = advance;
        cmd.func            = func_reg;
        cmd.channel         = channel_reg;
        cmd.reg_sel         = reg_sel_reg;
        cmd.write_data      = wdata_reg;
        cmd.debug_halt      = halt_reg;
        cmd.module_enable   = module_enable_reg;
        cmd.freeze_in_debug = freeze_reg;
    end

    pit_core #(
        .CHANNELS(CHANNELS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .res    (res)
    );

    // Result register: load on advance, drop once taken downstream
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rdata_reg  <= res.read_data;
            status_reg <= res.status;
            irq_reg    <= res.irq;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-DATA_W-3){1'b0}}, irq_reg, status_reg, rdata_reg};

endmodule
